// File: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: sv/nnsag_pkg.sv
package nnsag_pkg;

    // output frame geometry
    localparam int OUT_WIDTH  = 96;
    localparam int OUT_HEIGHT = 64;

    localparam int SRC_W  = 12;
    localparam int BASE_W = 32;
    localparam int IDX_W  = 13;
    localparam int LIN_W  = 2 * SRC_W;

    localparam int COL_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int ROW_W = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;

    // products col*src_width and row*src_height
    localparam int PX_W = COL_W + SRC_W;
    localparam int PY_W = ROW_W + SRC_W;

    // reciprocal constants: estimate is floor(p*M >> K), at most one low
    localparam int KX   = PX_W + 8;
    localparam int KY   = PY_W + 8;
    localparam int MX_W = KX + 1;
    localparam int MY_W = KY + 1;
    localparam longint unsigned MX_VAL = (64'd1 << KX) / 64'(OUT_WIDTH);
    localparam longint unsigned MY_VAL = (64'd1 << KY) / 64'(OUT_HEIGHT);
    localparam logic [MX_W-1:0] MX = MX_W'(MX_VAL);
    localparam logic [MY_W-1:0] MY = MY_W'(MY_VAL);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUT_WIDTH * OUT_HEIGHT - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE   = 2'd2;

    localparam logic [SRC_W-1:0]  RST_SRC_WIDTH  = 12'd96;
    localparam logic [SRC_W-1:0]  RST_SRC_HEIGHT = 12'd64;
    localparam logic [BASE_W-1:0] RST_SRC_BASE   = 32'd0;

    // front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } pix_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: sv/nnsag_front.sv
module nnsag_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                restart,
    output logic                in_stall,
    input  nnsag_pkg::q_status_t q_stat,
    output logic                push,
    output nnsag_pkg::pix_t     push_data
);
    import nnsag_pkg::*;

    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic             col_end, row_end;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        cur_col = restart ? '0 : col_reg;
        cur_row = restart ? '0 : row_reg;
        col_end = (cur_col == COL_W'(OUT_WIDTH - 1));
        row_end = (cur_row == ROW_W'(OUT_HEIGHT - 1));
        push_data.col  = cur_col;
        push_data.row  = cur_row;
        push_data.last = col_end && row_end;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_next = cur_col + 1'b1;
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: sv/nnsag_queue.sv
module nnsag_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nnsag_pkg::pix_t      push_data,
    input  logic                 pop,
    output nnsag_pkg::pix_t      pop_data,
    output nnsag_pkg::q_status_t q_stat
);
    import nnsag_pkg::*;

    pix_t            mem [Q_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QA_W:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == (QA_W+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/nnsag_back.sv
module nnsag_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nnsag_pkg::q_status_t          q_stat,
    output logic                          pop,
    input  nnsag_pkg::pix_t               pop_data,
    input  logic [nnsag_pkg::SRC_W-1:0]   src_width,
    input  logic [nnsag_pkg::SRC_W-1:0]   src_height,
    input  logic [nnsag_pkg::BASE_W-1:0]  src_base,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nnsag_pkg::IDX_W-1:0]   out_index,
    output logic [nnsag_pkg::SRC_W-1:0]   src_col,
    output logic [nnsag_pkg::SRC_W-1:0]   src_row,
    output logic [nnsag_pkg::BASE_W-1:0]  src_address,
    output logic                          frame_end
);
    import nnsag_pkg::*;

    logic en;

    // valid bits per stage
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;

    // payload carried down the pipe
    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic             s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [PX_W-1:0]  s1_px_reg, s2_px_reg;
    logic [PY_W-1:0]  s1_py_reg, s2_py_reg;
    logic [SRC_W-1:0] s2_qx_reg, s2_qy_reg;
    logic [SRC_W-1:0] s3_x_reg, s3_y_reg, s4_x_reg, s4_y_reg;
    logic [LIN_W-1:0] s4_lin_reg;
    logic [IDX_W-1:0] s5_idx_reg;
    logic [SRC_W-1:0] s5_x_reg, s5_y_reg;
    logic [BASE_W-1:0] s5_addr_reg;
    logic             s5_last_reg;

    logic [PX_W-1:0]      s1_px_next;
    logic [PY_W-1:0]      s1_py_next;
    logic [IDX_W-1:0]     s1_idx_next;
    logic [PX_W+MX_W-1:0] prod_x;
    logic [PY_W+MY_W-1:0] prod_y;
    logic [SRC_W-1:0]     s2_qx_next, s2_qy_next;
    logic [PX_W-1:0]      rem_x;
    logic [PY_W-1:0]      rem_y;
    logic [SRC_W-1:0]     s3_x_next, s3_y_next;
    logic [LIN_W-1:0]     s4_lin_next;
    logic [LIN_W:0]       lin_sum;
    logic [BASE_W-1:0]    s5_addr_next;

    // whole pipe moves unless the output holds a stalled result
    assign en  = !(s5_vld_reg && out_stall);
    assign pop = en && !q_stat.empty;

    always_comb
    begin
        s1_px_next  = PX_W'(pop_data.col) * PX_W'(src_width);
        s1_py_next  = PY_W'(pop_data.row) * PY_W'(src_height);
        s1_idx_next = IDX_W'(32'(pop_data.row) * 32'(OUT_WIDTH) + 32'(pop_data.col));

        // reciprocal estimate of the quotient
        prod_x     = (PX_W+MX_W)'(s1_px_reg) * (PX_W+MX_W)'(MX);
        prod_y     = (PY_W+MY_W)'(s1_py_reg) * (PY_W+MY_W)'(MY);
        s2_qx_next = prod_x[KX +: SRC_W];
        s2_qy_next = prod_y[KY +: SRC_W];

        // estimate is at most one low
        rem_x     = s2_px_reg - PX_W'(PX_W'(s2_qx_reg) * PX_W'(OUT_WIDTH));
        rem_y     = s2_py_reg - PY_W'(PY_W'(s2_qy_reg) * PY_W'(OUT_HEIGHT));
        s3_x_next = s2_qx_reg + SRC_W'(rem_x >= PX_W'(OUT_WIDTH));
        s3_y_next = s2_qy_reg + SRC_W'(rem_y >= PY_W'(OUT_HEIGHT));

        s4_lin_next = LIN_W'(s3_y_reg) * LIN_W'(src_width);

        lin_sum      = (LIN_W+1)'(s4_lin_reg) + (LIN_W+1)'(s4_x_reg);
        s5_addr_next = src_base + BASE_W'({lin_sum, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg   <= s1_px_next;
            s1_py_reg   <= s1_py_next;
            s1_idx_reg  <= s1_idx_next;
            s1_last_reg <= pop_data.last;

            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            s2_qx_reg   <= s2_qx_next;
            s2_qy_reg   <= s2_qy_next;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;

            s3_x_reg    <= s3_x_next;
            s3_y_reg    <= s3_y_next;
            s3_idx_reg  <= s2_idx_reg;
            s3_last_reg <= s2_last_reg;

            s4_lin_reg  <= s4_lin_next;
            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_idx_reg  <= s3_idx_reg;
            s4_last_reg <= s3_last_reg;

            s5_addr_reg <= s5_addr_next;
            s5_x_reg    <= s4_x_reg;
            s5_y_reg    <= s4_y_reg;
            s5_idx_reg  <= s4_idx_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pop;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    assign out_valid   = s5_vld_reg;
    assign out_index   = s5_idx_reg;
    assign src_col     = s5_x_reg;
    assign src_row     = s5_y_reg;
    assign src_address = s5_addr_reg;
    assign frame_end   = s5_last_reg;

endmodule

// File: sv/nearest_neighbor_scale_address_gen.sv
// channel | signals                                            | dir
// --------+----------------------------------------------------+-----
// input   | in_valid, in_stall, restart                        | in
// output  | out_valid, out_stall, out_index, src_col, src_row, | out
//         | src_address, frame_end                             |
// config  | cfg_write, cfg_index, cfg_data                     | in
//
// Path: the queue is written at the input transfer edge, then the result
//   passes the 5 back stages s1 to s5 before it is valid.
// Throughput: one pixel per cycle while in_stall is low; the back pipe is fully
//   staged, the queue write is the only front-side work.
// Reset: counters at pixel 0, registers at 96 x 64 source, base 0; no clearing pass.
// Output stall freezes the whole back pipe; the 2-entry queue then fills and
//   raises in_stall.
module nearest_neighbor_scale_address_gen (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nnsag_pkg::IDX_W-1:0]       out_index,
    output logic [nnsag_pkg::SRC_W-1:0]       src_col,
    output logic [nnsag_pkg::SRC_W-1:0]       src_row,
    output logic [nnsag_pkg::BASE_W-1:0]      src_address,
    output logic                              frame_end,
    input  logic                              cfg_write,
    input  logic [nnsag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nnsag_pkg::BASE_W-1:0]      cfg_data
);
    import nnsag_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    logic [SRC_W-1:0]  src_width_reg;
    logic [SRC_W-1:0]  src_height_reg;
    logic [BASE_W-1:0] src_base_reg;

    // front <-> queue <-> back
    logic      push, pop;
    pix_t      push_data, pop_data;
    q_status_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            src_base_reg   <= RST_SRC_BASE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                CFG_SRC_BASE:   src_base_reg   <= cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // raster counters, restart handling, last-pixel flag
    nnsag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .restart   (restart),
        .in_stall  (in_stall),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decouples the counters from the address pipe
    nnsag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // scale by reciprocal multiply, then linear byte address
    nnsag_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop         (pop),
        .pop_data    (pop_data),
        .src_width   (src_width_reg),
        .src_height  (src_height_reg),
        .src_base    (src_base_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_index   (out_index),
        .src_col     (src_col),
        .src_row     (src_row),
        .src_address (src_address),
        .frame_end   (frame_end)
    );

    `ASSERT_IMPLIES(a_queue_state, clk, rst_n, 1'b1, !(q_stat.full && q_stat.empty))
    `ASSERT_IMPLIES(a_end_index, clk, rst_n, out_valid && frame_end, out_index == LAST_IDX)
    `ASSERT_IMPLIES(a_col_range, clk, rst_n, out_valid && (src_width_reg != '0), src_col < src_width_reg)
    `ASSERT_IMPLIES(a_row_range, clk, rst_n, out_valid && (src_height_reg != '0), src_row < src_height_reg)

endmodule
